FILE: hw/rtl/string_hash_with_finalizer_core_assert.svh
// ----------------------------------------------------------------------------
// string_hash_with_finalizer_core_assert.svh
// assertion macros for the string hash core, clocked on i_clk, reset i_rst_n
// ----------------------------------------------------------------------------
`ifndef STRING_HASH_WITH_FINALIZER_CORE_ASSERT_SVH
`define STRING_HASH_WITH_FINALIZER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define SHF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define SHF_ASSERT_NEVER(lbl, cond, msg) \
    `SHF_ASSERT(lbl, !(cond), msg)

`else

`define SHF_ASSERT(lbl, prop, msg)
`define SHF_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: hw/rtl/shf_pkg.sv
// ----------------------------------------------------------------------------
// shf_pkg
// shared types and constants of the string hash core
// ----------------------------------------------------------------------------
package shf_pkg;

    // register indexes of the configuration port
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALGORITHM = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FINALIZE  = 8'd1;

    // per-byte rule codes, the unused code falls through to sdbm
    localparam logic [1:0] ALG_DEK  = 2'd0;
    localparam logic [1:0] ALG_DJB  = 2'd1;
    localparam logic [1:0] ALG_SDBM = 2'd2;

    localparam logic [31:0] DJB_INIT = 32'd5381;
    localparam int unsigned DEK_ROT = 5;

    // fmix64 multipliers
    localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned FMIX_SHIFT = 33;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // one pending result
    typedef struct packed {
        logic [31:0] hash;
        logic        finalize;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic busy;
        logic out_valid;
    } t_back_status;

    // finalizer sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_A,
        BK_MUL_B,
        BK_MIX1,
        BK_MUL_C,
        BK_MUL_D,
        BK_MUL_E,
        BK_MIX2
    } t_back_state;

endpackage

FILE: hw/rtl/string_hash_with_finalizer_core.sv
// String hash core. One string byte is taken per cycle while the job queue
// has room, and folded into a 32-bit running hash by the DEK, DJB or SDBM
// rule; the item marked last queues a result in a two-entry job queue. A
// result without finalizer passes from the job queue into the output register.
// With the fmix64 finalizer the back end runs five partial products through
// its single 32x32 multiplier for each result. Input stalls only when the job
// queue is full, so bytes stream at one byte per cycle while it has room.
// Configuration writes are accepted in every cycle.
`include "string_hash_with_finalizer_core_assert.svh"

// ----------------------------------------------------------------------------
// string_hash_with_finalizer_core
// top level: configuration registers, front, job queue and finalizer back
// ----------------------------------------------------------------------------
module string_hash_with_finalizer_core
    import shf_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_byte_value,
    input  logic                   i_first_of_string,
    input  logic                   i_last_of_string,
    input  logic [LENGTH_BITS-1:0] i_string_length,
    input  logic                   i_empty_string,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [31:0]            o_hash_value,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [1:0]   r_algorithm;
    logic         r_finalize;
    logic         q_push;
    t_job         q_push_job;
    logic         q_pop;
    t_job         q_pop_job;
    t_q_status    q_stat;
    t_back_status bk_stat;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_algorithm <= ALG_DEK;
            r_finalize  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_IDX_ALGORITHM) begin
                r_algorithm <= i_cfg_data[1:0];
            end
            if (i_cfg_index == CFG_IDX_FINALIZE) begin
                r_finalize <= i_cfg_data[0];
            end
        end
    end

    // byte front end
    shf_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_byte_value      (i_byte_value),
        .i_first_of_string (i_first_of_string),
        .i_last_of_string  (i_last_of_string),
        .i_string_length   (i_string_length),
        .i_empty_string    (i_empty_string),
        .i_algorithm       (r_algorithm),
        .i_finalize        (r_finalize),
        .i_q_stat          (q_stat),
        .o_push            (q_push),
        .o_job             (q_push_job)
    );

    // job queue
    shf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_job (q_push_job),
        .i_pop      (q_pop),
        .o_pop_job  (q_pop_job),
        .o_stat     (q_stat)
    );

    // finalizer and output register
    shf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_job        (q_pop_job),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value),
        .o_stat       (bk_stat)
    );

    // queue is never pushed when full nor popped when empty
    `SHF_ASSERT_NEVER(a_queue_overflow, q_push && q_stat.full, "job queue overflow")
    `SHF_ASSERT_NEVER(a_queue_underflow, q_pop && q_stat.empty, "job queue underflow")
    // a job leaves the queue only into an idle back end
    `SHF_ASSERT(a_pop_idle, q_pop |-> !bk_stat.busy, "job popped while finalizer busy")
    // a result appears only after a pop or a finalizer run
    `SHF_ASSERT(a_out_source, $rose(o_valid) |-> ($past(q_pop) || $past(bk_stat.busy)), "result without a job")

endmodule

FILE: hw/rtl/shf_front.sv
// ----------------------------------------------------------------------------
// shf_front
// takes string bytes, keeps the running hash, queues a job at end of string
// ----------------------------------------------------------------------------
module shf_front
    import shf_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_byte_value,
    input  logic                   i_first_of_string,
    input  logic                   i_last_of_string,
    input  logic [LENGTH_BITS-1:0] i_string_length,
    input  logic                   i_empty_string,
    input  logic [1:0]             i_algorithm,
    input  logic                   i_finalize,
    input  t_q_status              i_q_stat,
    output logic                   o_push,
    output t_job                   o_job
);

    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [31:0] init_value;
    logic [31:0] base;
    logic [31:0] byte_ext;
    logic        xfer;

    // room for a job is always kept so any item can be taken
    assign o_ready = !i_q_stat.full;
    assign xfer = i_valid && o_ready;
    assign byte_ext = {24'd0, i_byte_value};

    // initial value of the selected rule
    always_comb begin
        case (i_algorithm)
            ALG_DEK: init_value = 32'(i_string_length);
            ALG_DJB: init_value = DJB_INIT;
            default: init_value = 32'd0;
        endcase
    end

    // per-byte update, multiplies by 33 and 65599 as shift-add
    always_comb begin
        base = i_first_of_string ? init_value : r_hash;
        if (i_empty_string) begin
            n_hash = base;
        end else begin
            case (i_algorithm)
                ALG_DEK: n_hash = {base[31-DEK_ROT:0], base[31:32-DEK_ROT]} ^ byte_ext;
                ALG_DJB: n_hash = (base << 5) + base + byte_ext;
                default: n_hash = (base << 16) + (base << 6) - base + byte_ext;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= 32'd0;
        end else if (xfer) begin
            r_hash <= n_hash;
        end
    end

    // job goes out in the transfer cycle
    assign o_push = xfer && i_last_of_string;
    assign o_job.hash = n_hash;
    assign o_job.finalize = i_finalize;

endmodule

FILE: hw/rtl/shf_queue.sv
// ----------------------------------------------------------------------------
// shf_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module shf_queue
    import shf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_push_job,
    input  logic      i_pop,
    output t_job      o_pop_job,
    output t_q_status o_stat
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_stat.full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_pop_job = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/shf_back.sv
// ----------------------------------------------------------------------------
// shf_back
// fmix64 finalizer on one shared 32x32 multiplier, plus the output register
// ----------------------------------------------------------------------------
module shf_back
    import shf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_q_status    i_q_stat,
    input  t_job         i_job,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [31:0]  o_hash_value,
    output t_back_status o_stat
);

    t_back_state r_state;
    t_back_state n_state;

    logic [63:0] r_k;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic        r_out_valid;
    logic [31:0] r_out_hash;

    logic        out_free;
    logic        take_job;
    logic        bypass;
    logic        mul_en;
    logic        acc_load;
    logic        acc_add;
    logic        k_load;
    logic        out_load_mix;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] mixed;

    assign out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty && out_free && i_job.finalize) begin
                    n_state = BK_MUL_A;
                end
            end
            BK_MUL_A: n_state = BK_MUL_B;
            BK_MUL_B: n_state = BK_MIX1;
            BK_MIX1:  n_state = BK_MUL_C;
            BK_MUL_C: n_state = BK_MUL_D;
            BK_MUL_D: n_state = BK_MUL_E;
            BK_MUL_E: n_state = BK_MIX2;
            BK_MIX2: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    // control and multiplier operands
    always_comb begin
        take_job     = 1'b0;
        mul_en       = 1'b0;
        acc_load     = 1'b0;
        acc_add      = 1'b0;
        k_load       = 1'b0;
        out_load_mix = 1'b0;
        op_a         = r_k[31:0];
        op_b         = FMIX_C1[31:0];
        case (r_state)
            BK_IDLE:  take_job = !i_q_stat.empty && out_free;
            BK_MUL_A: mul_en = 1'b1;
            BK_MUL_B: begin
                mul_en   = 1'b1;
                acc_load = 1'b1;
                op_b     = FMIX_C1[63:32];
            end
            BK_MIX1:  k_load = 1'b1;
            BK_MUL_C: begin
                mul_en = 1'b1;
                op_b   = FMIX_C2[31:0];
            end
            BK_MUL_D: begin
                mul_en   = 1'b1;
                acc_load = 1'b1;
                op_b     = FMIX_C2[63:32];
            end
            BK_MUL_E: begin
                mul_en  = 1'b1;
                acc_add = 1'b1;
                op_a    = r_k[63:32];
                op_b    = FMIX_C2[31:0];
            end
            BK_MIX2:  out_load_mix = out_free;
            default:  take_job = 1'b0;
        endcase
    end

    assign bypass = take_job && !i_job.finalize;
    assign o_pop = take_job;

    // product, partial sum modulo 2^64 and the xor-shift step
    assign prod = {32'd0, op_a} * {32'd0, op_b};
    assign sum = r_acc + {r_prod[31:0], 32'd0};
    assign mixed = sum ^ (sum >> FMIX_SHIFT);

    // datapath registers; the first xor-shift is a no-op on a 32-bit value
    always_ff @(posedge i_clk) begin
        if (take_job) begin
            r_k <= {32'd0, i_job.hash};
        end else if (k_load) begin
            r_k <= mixed;
        end
        if (mul_en) begin
            r_prod <= prod;
        end
        if (acc_load) begin
            r_acc <= r_prod;
        end else if (acc_add || k_load) begin
            r_acc <= sum;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (bypass) begin
            r_out_hash <= i_job.hash;
        end else if (out_load_mix) begin
            r_out_hash <= mixed[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (bypass || out_load_mix) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_hash_value = r_out_hash;
    assign o_stat.busy = (r_state != BK_IDLE);
    assign o_stat.out_valid = r_out_valid;

endmodule
